// File: sv/ktm_pkg.sv
// ktm_pkg: shared types and constants for the keyword trie matcher.
// No dependencies; imported by keyword_trie_matcher.
package ktm_pkg;

   // printable alphabet: space up to, but not including, 127
   localparam logic [7:0] FIRST_CH = 8'd32;
   localparam logic [7:0] END_CH   = 8'd127;
   localparam int         SYMS     = 95;

   localparam int IDX_W = 12;

   // result status codes
   localparam logic [2:0] ST_INSERTED = 3'd0;
   localparam logic [2:0] ST_DUP      = 3'd1;
   localparam logic [2:0] ST_FULL     = 3'd2;
   localparam logic [2:0] ST_BAD      = 3'd3;
   localparam logic [2:0] ST_LOOKUP   = 3'd4;

   // sticky insert error codes
   localparam logic [1:0] ERR_NONE = 2'd0;
   localparam logic [1:0] ERR_FULL = 2'd2;
   localparam logic [1:0] ERR_BAD  = 2'd3;

   localparam logic MODE_INSERT = 1'b0;

   typedef enum logic [3:0] {
      S_CLEAR = 4'b0001,
      S_IDLE  = 4'b0010,
      S_WALK  = 4'b0100,
      S_TERM  = 4'b1000
   } state_type;

endpackage

// File: sv/keyword_trie_matcher.sv
// Keyword trie matcher: insert and look up printable keywords, one character a word.
// A last word's response goes to the result register from S_TERM, after S_WALK. A word is
// taken only in S_IDLE, so each is finished before the next; the pace is set by the child-store
// read whose data becomes the cursor for the next character, and the terminal-store read after
// it. A last word holds in S_TERM while the previous response is still waiting under rsp_stall.
// Reset: synchronous; a clearing pass over all NODES*95 child slots (97280 at default) zeroes
// both stores, with req_stall held high throughout. Depends on ktm_pkg and ktm_ram.
module keyword_trie_matcher
   import ktm_pkg::*;
#(
   parameter int NODES = 1024,
   parameter int ITEMS = 4096
) (
   input  logic             clock,
   input  logic             reset,
   // request channel
   input  logic             req_valid,
   output logic             req_stall,
   input  logic             req_mode,
   input  logic [7:0]       req_ch,
   input  logic             req_last,
   input  logic [IDX_W-1:0] req_item_index,
   // response channel
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [2:0]       rsp_status,
   output logic [IDX_W-1:0] rsp_match_index
);

   // node numbers, free-node counter (holds NODES itself), child slots
   localparam int NW    = $clog2(NODES);
   localparam int FW    = NW + 1;
   localparam int SLOTS = NODES * SYMS;
   localparam int SW    = $clog2(SLOTS);
   localparam logic [SW-1:0]    SLOT_STRIDE = SW'(SYMS);
   localparam logic [SW-1:0]    LAST_SLOT   = SW'(SLOTS - 1);
   localparam logic [FW-1:0]    NODES_F     = FW'(NODES);
   localparam logic [NW-1:0]    ROOT        = NW'(1);
   localparam logic [16:0]      ITEMS_W     = 17'(ITEMS);
   localparam logic [IDX_W-1:0] IDX_MAX     = IDX_W'(ITEMS - 1);

   // ---------------------------------------------------------------
   // control state
   // ---------------------------------------------------------------
   state_type        state_ff, state_in;
   logic [SW-1:0]    clr_cnt_ff, clr_cnt_in;
   logic [NW-1:0]    cursor_ff, cursor_in;
   logic [FW-1:0]    next_free_ff, next_free_in;
   logic             failed_ff, failed_in;
   logic [1:0]       err_ff, err_in;

   // captured word
   logic             mode_ff, last_ff, printable_ff;
   logic [IDX_W-1:0] idx_ff;
   logic [SW-1:0]    slot_ff;

   // result register
   logic             rsp_valid_ff, rsp_valid_in;
   logic [2:0]       status_ff, status_in;
   logic [IDX_W-1:0] match_ff, match_in;

   // store ports
   logic             child_we, child_re;
   logic [SW-1:0]    child_waddr, child_raddr;
   logic [NW-1:0]    child_wdata, child_rdata;
   logic             term_we, term_re;
   logic [NW-1:0]    term_waddr, term_raddr;
   logic [IDX_W-1:0] term_wdata, term_rdata;

   logic             accept;
   logic             req_printable;
   logic [6:0]       ch_off;
   logic [SW-1:0]    req_slot;
   logic [IDX_W-1:0] req_idx_sat;
   logic             rsp_free;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;

   assign req_printable = (req_ch >= FIRST_CH) && (req_ch < END_CH);
   // only meaningful for printable characters; bit 7 is then zero
   assign ch_off   = req_ch[6:0] - FIRST_CH[6:0];
   assign req_slot = SW'(cursor_ff) * SLOT_STRIDE + SW'(ch_off);
   assign req_idx_sat = ({5'd0, req_item_index} >= ITEMS_W) ? IDX_MAX : req_item_index;

   // result register can take a new word this cycle
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   // child read is issued at accept; its data arrives in S_WALK
   assign child_re    = accept && req_printable;
   assign child_raddr = req_slot;

   // ---------------------------------------------------------------
   // sequencer
   //   S_CLEAR : zero child and terminal stores, one entry a cycle
   //   S_IDLE  : take a word, launch the child read
   //   S_WALK  : step the cursor, allocate a node if inserting
   //   S_TERM  : last word only; read the terminal entry, written back on an insert without error
   // Each access to a store entry finishes before the next one issues,
   // so no forwarding is needed.
   // ---------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      cursor_in    = cursor_ff;
      next_free_in = next_free_ff;
      failed_in    = failed_ff;
      err_in       = err_ff;
      status_in    = status_ff;
      match_in     = match_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      child_we     = 1'b0;
      child_waddr  = slot_ff;
      child_wdata  = next_free_ff[NW-1:0];
      term_we      = 1'b0;
      term_waddr   = cursor_ff;
      term_wdata   = idx_ff;
      term_re      = 1'b0;
      term_raddr   = cursor_ff;

      case (state_ff)
         S_CLEAR: begin
            child_we    = 1'b1;
            child_waddr = clr_cnt_ff;
            child_wdata = '0;
            term_we     = ({1'b0, clr_cnt_ff} < (SW+1)'(NODES));
            term_waddr  = clr_cnt_ff[NW-1:0];
            term_wdata  = '0;
            clr_cnt_in  = clr_cnt_ff + SW'(1);
            if (clr_cnt_ff == LAST_SLOT) begin
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            if (accept) begin
               state_in = S_WALK;
            end
         end

         S_WALK: begin
            if (mode_ff == MODE_INSERT) begin
               if (err_ff == ERR_NONE) begin
                  if (!printable_ff) begin
                     err_in = ERR_BAD;
                  end else if (child_rdata != '0) begin
                     cursor_in = child_rdata;
                  end else if (next_free_ff >= NODES_F) begin
                     err_in = ERR_FULL;
                  end else begin
                     child_we     = 1'b1;
                     cursor_in    = next_free_ff[NW-1:0];
                     next_free_in = next_free_ff + FW'(1);
                  end
               end
            end else begin
               if (!failed_ff) begin
                  if (!printable_ff || child_rdata == '0) begin
                     failed_in = 1'b1;
                  end else begin
                     cursor_in = child_rdata;
                  end
               end
            end
            if (last_ff) begin
               term_re    = 1'b1;
               term_raddr = cursor_in;
               state_in   = S_TERM;
            end else begin
               state_in = S_IDLE;
            end
         end

         S_TERM: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               match_in     = '0;
               if (mode_ff == MODE_INSERT) begin
                  if (err_ff != ERR_NONE) begin
                     status_in = {1'b0, err_ff};
                  end else begin
                     term_we   = 1'b1;
                     status_in = (term_rdata != '0) ? ST_DUP : ST_INSERTED;
                  end
               end else begin
                  status_in = ST_LOOKUP;
                  match_in  = failed_ff ? '0 : term_rdata;
               end
               // end of string: back to the root, sticky flags cleared
               cursor_in = ROOT;
               failed_in = 1'b0;
               err_in    = ERR_NONE;
               state_in  = S_IDLE;
            end
         end

         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_cnt_ff   <= '0;
         cursor_ff    <= ROOT;
         next_free_ff <= FW'(2);
         failed_ff    <= 1'b0;
         err_ff       <= ERR_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         cursor_ff    <= cursor_in;
         next_free_ff <= next_free_in;
         failed_ff    <= failed_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff      <= req_mode;
         last_ff      <= req_last;
         printable_ff <= req_printable;
         idx_ff       <= req_idx_sat;
         slot_ff      <= req_slot;
      end
      status_ff <= status_in;
      match_ff  <= match_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_match_index = match_ff;

   // ---------------------------------------------------------------
   // stores
   // ---------------------------------------------------------------
   ktm_ram #(
      .DEPTH (SLOTS),
      .WIDTH (NW)
   ) u_child (
      .clock (clock),
      .we    (child_we),
      .waddr (child_waddr),
      .wdata (child_wdata),
      .re    (child_re),
      .raddr (child_raddr),
      .rdata (child_rdata)
   );

   ktm_ram #(
      .DEPTH (NODES),
      .WIDTH (IDX_W)
   ) u_term (
      .clock (clock),
      .we    (term_we),
      .waddr (term_waddr),
      .wdata (term_wdata),
      .re    (term_re),
      .raddr (term_raddr),
      .rdata (term_rdata)
   );

   // ---------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------
   a_free_range: assert property (@(posedge clock) disable iff (reset)
      (next_free_ff >= FW'(2)) && (next_free_ff <= NODES_F))
      else $error("free-node counter out of range");

   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      {1'b0, cursor_ff} < NODES_F)
      else $error("cursor beyond node count");

   a_alloc_nonzero: assert property (@(posedge clock) disable iff (reset)
      (child_we && state_ff == S_WALK) |-> (child_wdata != '0))
      else $error("child link written as null");

   a_rsp_from_term: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_TERM))
      else $error("response raised outside terminal step");

   a_root_after_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_TERM && rsp_free) |=>
         (cursor_ff == ROOT && !failed_ff && err_ff == ERR_NONE))
      else $error("cursor not returned to root after last word");

endmodule

// File: sv/ktm_ram.sv
// ktm_ram: simple dual-port synchronous RAM, one write and one read port,
// registered read data. No dependencies.
module ktm_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 10,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // read data holds while re is low
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule
